// ===== hdl/gcbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcbd_pkg
// Shared constants, types and denomination table for the greedy change unit.
// ----------------------------------------------------------------------------
package gcbd_pkg;

  localparam int AMOUNT_BITS   = 24;
  localparam int NUM_DENOM_CFG = 15;

  localparam int FULL_LIST = 15;
  localparam int COIN_LIST = 8;
  localparam int NUM_DENOM = (NUM_DENOM_CFG < COIN_LIST) ? COIN_LIST :
                             (NUM_DENOM_CFG > FULL_LIST) ? FULL_LIST : NUM_DENOM_CFG;

  localparam int FIRST_BILL = FULL_LIST - NUM_DENOM;
  localparam int FIRST_COIN = FULL_LIST - COIN_LIST;
  localparam int CHAIN_LEN  = FULL_LIST - 1 - FIRST_BILL;

  localparam int DENOM_W = 16;
  localparam int COUNT_W = 17;
  localparam int SMALL_W = 2;
  localparam int REM_W   = 16;
  localparam int IDX_W   = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [DENOM_W-1:0] DENOMS [FULL_LIST] = '{
    16'd50000, 16'd20000, 16'd10000, 16'd5000, 16'd2000, 16'd1000, 16'd500, 16'd200,
    16'd100, 16'd50, 16'd20, 16'd10, 16'd5, 16'd2, 16'd1
  };

  // The first divisor is at least 200, so the reciprocal stays below 2^(AMOUNT_BITS-7).
  localparam int RECIP_W = AMOUNT_BITS - 7;
  localparam longint unsigned RECIP_BILL = (64'd1 << AMOUNT_BITS) / 64'(DENOMS[FIRST_BILL]);
  localparam longint unsigned RECIP_COIN = (64'd1 << AMOUNT_BITS) / 64'(DENOMS[FIRST_COIN]);

  typedef struct packed {
    logic [REM_W-1:0]                   rest;
    logic [COUNT_W-1:0]                 first_cnt;
    logic [FULL_LIST-1:0][SMALL_W-1:0]  small_cnt;
  } item_t;

endpackage

// ===== hdl/greedy_change_by_division_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_change_by_division_unit
// Greedy split of a cent amount over euro denominations, one transfer per
// denomination used.
// ----------------------------------------------------------------------------
// An amount enters in any cycle in which the pipeline has room. It passes a
// three-stage divider by the largest active denomination, then one stage per
// further denomination, and then the output serializer.
// Each amount then takes as many output transfers as it uses denominations,
// one to fifteen, and an amount of zero takes none; while the output
// serializer holds a split, it takes the next amount only as that split's
// last transfer is taken. use_bills resets to 1; the user must write it
// only while the unit is idle, and the unit itself does not enforce this.
module greedy_change_by_division_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [gcbd_pkg::AMOUNT_BITS-1:0]    amount_cents_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [gcbd_pkg::DENOM_W-1:0]        denomination_cents_o,
  output logic [gcbd_pkg::COUNT_W-1:0]        piece_count_o,
  output logic                                last_piece_o
);

  logic            use_bills_q;
  logic            div_valid, div_ready, chain_valid, chain_ready;
  gcbd_pkg::item_t div_item, chain_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_bills_q <= 1'b1;
    end else if (cfg_we_i) begin
      use_bills_q <= cfg_wdata_i;
    end
  end

  gcbd_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .use_bills_i (use_bills_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .amount_i    (amount_cents_i),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .item_o      (div_item)
  );

  gcbd_chain u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .use_bills_i (use_bills_q),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .item_i      (div_item),
    .out_valid_o (chain_valid),
    .out_ready_i (chain_ready),
    .item_o      (chain_item)
  );

  gcbd_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .use_bills_i (use_bills_q),
    .in_valid_i  (chain_valid),
    .in_ready_o  (chain_ready),
    .item_i      (chain_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .denom_o     (denomination_cents_o),
    .count_o     (piece_count_o),
    .last_o      (last_piece_o)
  );

endmodule

// ===== hdl/gcbd_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcbd_divider
// Three-stage division of the amount by the largest active denomination.
// ----------------------------------------------------------------------------
module gcbd_divider (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 use_bills_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [gcbd_pkg::AMOUNT_BITS-1:0]     amount_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output gcbd_pkg::item_t                      item_o
);

  localparam int AmtW   = gcbd_pkg::AMOUNT_BITS;
  localparam int RecipW = gcbd_pkg::RECIP_W;
  localparam int ProdW  = AmtW + RecipW;
  localparam int QdW    = RecipW + gcbd_pkg::DENOM_W;
  localparam int RemW   = gcbd_pkg::REM_W;
  localparam int CntW   = gcbd_pkg::COUNT_W;

  logic [RecipW-1:0]            recip;
  logic [gcbd_pkg::DENOM_W-1:0] denom;

  logic              v1_q, v2_q, v3_q;
  logic              en1, en2, en3;
  logic [AmtW-1:0]   amt1_q, amt2_q;
  logic [ProdW-1:0]  prod1_q;
  logic [RecipW-1:0] qest2_q;
  logic [QdW-1:0]    qd2_q;

  logic [AmtW-1:0]   rem_raw;
  logic              corr;
  logic [63:0]       rem_fix;
  logic [RecipW:0]   quot;
  gcbd_pkg::item_t   item_d, item_q;

  assign recip = use_bills_i ? RecipW'(gcbd_pkg::RECIP_BILL) : RecipW'(gcbd_pkg::RECIP_COIN);
  assign denom = use_bills_i ? gcbd_pkg::DENOMS[gcbd_pkg::FIRST_BILL]
                             : gcbd_pkg::DENOMS[gcbd_pkg::FIRST_COIN];

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_comb begin
    rem_raw = amt2_q - AmtW'(qd2_q);
    corr    = 64'(rem_raw) >= 64'(denom);
    rem_fix = corr ? (64'(rem_raw) - 64'(denom)) : 64'(rem_raw);
    quot    = {1'b0, qest2_q} + (RecipW + 1)'(corr);
    item_d           = '0;
    item_d.rest      = RemW'(rem_fix);
    if (64'(quot) > 64'(gcbd_pkg::COUNT_MAX)) begin
      item_d.first_cnt = gcbd_pkg::COUNT_MAX;
    end else begin
      item_d.first_cnt = CntW'(quot);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      amt1_q  <= amount_i;
      prod1_q <= ProdW'(amount_i) * ProdW'(recip);
    end
    if (en2) begin
      amt2_q  <= amt1_q;
      qest2_q <= prod1_q[ProdW-1:AmtW];
      qd2_q   <= QdW'(prod1_q[ProdW-1:AmtW]) * QdW'(denom);
    end
    if (en3) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = v3_q;
  assign item_o      = item_q;

endmodule

// ===== hdl/gcbd_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcbd_chain
// One register stage per remaining denomination; each takes zero, one or two
// pieces off the running remainder.
// ----------------------------------------------------------------------------
module gcbd_chain (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            use_bills_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  gcbd_pkg::item_t item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output gcbd_pkg::item_t item_o
);

  localparam int Len   = gcbd_pkg::CHAIN_LEN;
  localparam int RemXW = gcbd_pkg::REM_W + 1;
  localparam int RemW  = gcbd_pkg::REM_W;

  logic            valid [Len+1];
  logic            ready [Len+1];
  gcbd_pkg::item_t item  [Len+1];

  assign valid[0]    = in_valid_i;
  assign item[0]     = item_i;
  assign in_ready_o  = ready[0];
  assign ready[Len]  = out_ready_i;
  assign out_valid_o = valid[Len];
  assign item_o      = item[Len];

  for (genvar j = 0; j < Len; j++) begin : g_stage
    localparam int Idx = gcbd_pkg::FIRST_BILL + 1 + j;
    localparam logic [RemXW-1:0] D1 = RemXW'(gcbd_pkg::DENOMS[Idx]);
    localparam logic [RemXW-1:0] D2 = D1 << 1;
    localparam bit AlwaysOn = (Idx > gcbd_pkg::FIRST_COIN);

    logic            valid_q;
    gcbd_pkg::item_t item_q, item_d;
    logic [RemXW-1:0] rest_x;
    logic            active;

    assign active   = use_bills_i || AlwaysOn;
    assign ready[j] = !valid_q || ready[j+1];

    always_comb begin
      rest_x = {1'b0, item[j].rest};
      item_d = item[j];
      if (active && (rest_x >= D2)) begin
        item_d.small_cnt[Idx] = 2'd2;
        item_d.rest           = RemW'(rest_x - D2);
      end else if (active && (rest_x >= D1)) begin
        item_d.small_cnt[Idx] = 2'd1;
        item_d.rest           = RemW'(rest_x - D1);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else if (ready[j]) begin
        valid_q <= valid[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ready[j]) begin
        item_q <= item_d;
      end
    end

    assign valid[j+1] = valid_q;
    assign item[j+1]  = item_q;
  end

endmodule

// ===== hdl/gcbd_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcbd_serializer
// Holds one finished split and sends its nonzero denominations one per transfer,
// largest first.
// ----------------------------------------------------------------------------
module gcbd_serializer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            use_bills_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  gcbd_pkg::item_t                 item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [gcbd_pkg::DENOM_W-1:0]    denom_o,
  output logic [gcbd_pkg::COUNT_W-1:0]    count_o,
  output logic                            last_o
);

  localparam int N    = gcbd_pkg::FULL_LIST;
  localparam int IdxW = gcbd_pkg::IDX_W;
  localparam int CntW = gcbd_pkg::COUNT_W;

  logic [N-1:0]                       mask_q, mask_d, new_mask, onehot, rest_mask;
  logic [CntW-1:0]                    first_cnt_q;
  logic [N-1:0][gcbd_pkg::SMALL_W-1:0] small_q;
  logic [IdxW-1:0]                    first_idx;

  assign first_idx = use_bills_i ? IdxW'(gcbd_pkg::FIRST_BILL) : IdxW'(gcbd_pkg::FIRST_COIN);

  assign onehot      = mask_q & (~mask_q + N'(1));
  assign rest_mask   = mask_q & ~onehot;
  assign out_valid_o = |mask_q;
  assign last_o      = ~|rest_mask;
  assign in_ready_o  = !(|mask_q) || (out_ready_i && last_o);

  always_comb begin
    for (int k = 0; k < N; k++) begin
      new_mask[k] = (item_i.small_cnt[k] != '0) ||
                    ((IdxW'(k) == first_idx) && (item_i.first_cnt != '0));
    end
  end

  always_comb begin
    denom_o = '0;
    count_o = '0;
    for (int k = 0; k < N; k++) begin
      if (onehot[k]) begin
        denom_o = denom_o | gcbd_pkg::DENOMS[k];
        count_o = count_o | ((IdxW'(k) == first_idx) ? first_cnt_q : CntW'(small_q[k]));
      end
    end
  end

  always_comb begin
    mask_d = mask_q;
    if (out_valid_o && out_ready_i) begin
      mask_d = rest_mask;
    end
    if (in_valid_i && in_ready_o) begin
      mask_d = new_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      first_cnt_q <= item_i.first_cnt;
      small_q     <= item_i.small_cnt;
    end
  end

endmodule

// ===== tb/greedy_change_by_division_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_change_by_division_unit_test
// Self-checking testbench for the greedy euro change splitter.
// ----------------------------------------------------------------------------
// Amounts are sent over the input channel in bursts with random gaps, while
// the result channel stalls on its own random pattern. Once, the result side
// holds off for a long stretch so that the unit fills up and stops taking
// input. Every accepted amount is split in the testbench over the active
// denominations, and each result transfer is checked in order against that
// split. The run covers both settings of use_bills, and each is set more
// than once. The first run of each setting starts with a directed set:
// zero, the field extremes, every denomination used at once, and exact
// denomination boundaries. Random amounts follow.
// ----------------------------------------------------------------------------
module greedy_change_by_division_unit_test;
  localparam int AMOUNT_BITS = gcbd_pkg::AMOUNT_BITS;
  localparam int DENOM_W     = gcbd_pkg::DENOM_W;
  localparam int COUNT_W     = gcbd_pkg::COUNT_W;

  localparam int NUM_VALUES = 15;
  localparam int COIN_START = 7;
  localparam longint unsigned COUNT_LIMIT = 131071;
  localparam longint unsigned EURO_VALUES [NUM_VALUES] = '{
    50000, 20000, 10000, 5000, 2000, 1000, 500, 200, 100, 50, 20, 10, 5, 2, 1
  };
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 40;

  typedef enum int {READY_ALWAYS, READY_COIN_FLIP, READY_SHORT_STALLS} ready_mode_e;

  typedef struct {
    logic [DENOM_W-1:0] denom;
    logic [COUNT_W-1:0] count;
    logic               last;
  } piece_t;

  class change_book;
    piece_t owed_pieces[$];
    bit     bills_on = 1'b1;
    int     errors   = 0;

    function void note_amount(logic [AMOUNT_BITS-1:0] amount);
      longint unsigned rest;
      longint unsigned cnt;
      int              first;
      piece_t          p;
      piece_t          split[$];
      rest  = 64'(amount);
      first = bills_on ? 0 : COIN_START;
      for (int i = first; i < NUM_VALUES; i++) begin
        cnt  = rest / EURO_VALUES[i];
        rest = rest - cnt * EURO_VALUES[i];
        if (cnt != 0) begin
          p.denom = DENOM_W'(EURO_VALUES[i]);
          p.count = COUNT_W'((cnt > COUNT_LIMIT) ? COUNT_LIMIT : cnt);
          p.last  = 1'b0;
          split.insert(split.size(), p);
        end
      end
      if (split.size() != 0) begin
        split[split.size()-1].last = 1'b1;
      end
      foreach (split[i]) begin
        owed_pieces.insert(owed_pieces.size(), split[i]);
      end
    endfunction

    function void check_piece(logic [DENOM_W-1:0] denom, logic [COUNT_W-1:0] count,
                              logic last);
      piece_t want;
      if (owed_pieces.size() == 0) begin
        $display("%0t: unexpected transfer, denomination %0d count %0d last %0b",
                 $time, denom, count, last);
        errors++;
      end else begin
        want = owed_pieces.pop_front();
        if (denom !== want.denom) begin
          $display("%0t: denomination expected %0d, actual %0d", $time, want.denom, denom);
          errors++;
        end
        if (count !== want.count) begin
          $display("%0t: piece count expected %0d, actual %0d", $time, want.count, count);
          errors++;
        end
        if (last !== want.last) begin
          $display("%0t: last piece expected %0b, actual %0b", $time, want.last, last);
          errors++;
        end
      end
    endfunction

    function int pending();
      return owed_pieces.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic                   cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [AMOUNT_BITS-1:0] amount_cents_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [DENOM_W-1:0]     denomination_cents_o;
  logic [COUNT_W-1:0]     piece_count_o;
  logic                   last_piece_o;

  change_book book = new();
  bit         hold_off_req  = 1'b0;
  bit         hold_off_done = 1'b0;
  int         burst_left    = 0;

  greedy_change_by_division_unit DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .amount_cents_i       (amount_cents_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .denomination_cents_o (denomination_cents_o),
    .piece_count_o        (piece_count_o),
    .last_piece_o         (last_piece_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("** greedy_change_by_division_unit: FAILED **");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        book.check_piece(denomination_cents_o, piece_count_o, last_piece_o);
      end
    end
  end

  initial begin
    ready_mode_e mode;
    int          mode_left;
    int          stall_left;
    int          hold_cnt;
    mode        = READY_ALWAYS;
    mode_left   = 0;
    stall_left  = 0;
    hold_cnt    = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        out_ready_i <= 1'b0;
        hold_cnt++;
        if (hold_cnt == HOLD_OFF_CYCLES) hold_off_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = ready_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        case (mode)
          READY_ALWAYS: begin
            out_ready_i <= 1'b1;
          end
          READY_COIN_FLIP: begin
            out_ready_i <= 1'($urandom_range(0, 1));
          end
          default: begin
            if (stall_left > 0) begin
              out_ready_i <= 1'b0;
              stall_left--;
            end else if ($urandom_range(0, 7) == 0) begin
              out_ready_i <= 1'b0;
              stall_left = $urandom_range(0, 5);
            end else begin
              out_ready_i <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  task automatic offer_amount(logic [AMOUNT_BITS-1:0] amount);
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    amount_cents_i <= amount;
    do @(posedge clk_i); while (!in_ready_o);
    book.note_amount(amount);
  endtask

  task automatic idle_input(int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    while (book.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_use_bills(bit value);
    idle_input(1);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    book.bills_on = value;
  endtask

  function automatic logic [AMOUNT_BITS-1:0] pick_amount();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return AMOUNT_BITS'($urandom_range(1, 500));
      3, 4:    return AMOUNT_BITS'($urandom_range(1, 100000));
      5:       return AMOUNT_BITS'(EURO_VALUES[$urandom_range(0, NUM_VALUES-1)] *
                                   $urandom_range(1, 3));
      default: return AMOUNT_BITS'($urandom());
    endcase
  endfunction

  task automatic send_random(int count);
    repeat (count) begin
      if (burst_left == 0) begin
        idle_input($urandom_range(1, 10));
        burst_left = $urandom_range(1, 25);
      end
      offer_amount(pick_amount());
      burst_left--;
    end
  endtask

  task automatic send_list(logic [AMOUNT_BITS-1:0] amounts[$]);
    foreach (amounts[i]) offer_amount(amounts[i]);
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = 1'b0;
    in_valid_i     = 1'b0;
    amount_cents_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Bills and coins: zero, every denomination at once, boundaries, extremes.
    send_list('{24'd0, 24'd1, 24'd3, 24'd9, 24'd199, 24'd200, 24'd388, 24'd499,
                24'd500, 24'd49999, 24'd50000, 24'd88888, 24'd99999, 24'd100000,
                24'd0, 24'hFFFFFF, 24'h800000, 24'h555555, 24'hAAAAAA});
    write_use_bills(1'b1);
    send_list('{24'd88888, 24'd1});
    hold_off_req = 1'b1;
    send_random(70);

    // Coins only: the count of 2 euro pieces reaches its largest value here.
    write_use_bills(1'b0);
    send_list('{24'd0, 24'd1, 24'd199, 24'd200, 24'd388, 24'd88888, 24'hFFFFFF,
                24'hAAAAAA, 24'h555555});
    send_random(70);

    write_use_bills(1'b1);
    send_random(50);
    write_use_bills(1'b0);
    send_random(50);

    idle_input(1);
    wait_drained();
    if (book.errors == 0) begin
      $display("** greedy_change_by_division_unit: PASSED **");
    end else begin
      $display("** greedy_change_by_division_unit: FAILED **");
    end
    $finish;
  end

endmodule
